// ----- sv/ring_buffer_crlf_line_reader_assert.svh -----
// Assertion macros used by the line reader top level.
`ifndef RING_BUFFER_CRLF_LINE_READER_ASSERT_SVH
`define RING_BUFFER_CRLF_LINE_READER_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define RBCL_ASSERT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define RBCL_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- sv/rbcl_pkg.sv -----
// Package with constants, types and helpers of the CRLF line reader.
`timescale 1ns / 1ps

package rbcl_pkg;

    localparam int DEPTH       = 256;
    localparam int MAX_LINE    = 32;
    localparam int AW          = $clog2(DEPTH);
    localparam int QUEUE_DEPTH = 2;
    localparam int QAW         = $clog2(QUEUE_DEPTH);
    localparam int QCW         = $clog2(QUEUE_DEPTH + 1);

    localparam logic [AW:0] DEPTH_X = DEPTH[AW:0];
    localparam logic [7:0]  CH_CR   = 8'h0D;
    localparam logic [7:0]  CH_LF   = 8'h0A;

    typedef logic [AW-1:0] t_ptr;

    typedef enum logic [1:0] {
        OP_PUSH  = 2'd0,
        OP_READ  = 2'd1,
        OP_CLEAR = 2'd2,
        OP_NONE  = 2'd3
    } t_op;

    typedef enum logic [2:0] {
        ST_STORED   = 3'd0,
        ST_DROPPED  = 3'd1,
        ST_LINE_OK  = 3'd2,
        ST_EMPTY    = 3'd3,
        ST_TOO_LONG = 3'd4,
        ST_NO_LINE  = 3'd5,
        ST_CLEARED  = 3'd6
    } t_status;

    typedef enum logic [1:0] {
        CMD_PUSH  = 2'd0,
        CMD_READ  = 2'd1,
        CMD_CLEAR = 2'd2
    } t_cmd_kind;

    typedef struct packed {
        t_cmd_kind  kind;
        logic [7:0] data;
    } t_cmd;

    typedef enum logic [1:0] {
        BK_IDLE = 2'd0,
        BK_SCAN = 2'd1,
        BK_EMIT = 2'd2,
        BK_FIN  = 2'd3
    } t_back_state;

    // Ring index addition; both operands are below DEPTH.
    function automatic t_ptr wrap_add(t_ptr a, t_ptr b);
        logic [AW:0] s;
        s = {1'b0, a} + {1'b0, b};
        if (s >= DEPTH_X) begin
            s = s - DEPTH_X;
        end
        return s[AW-1:0];
    endfunction

    // Number of bytes held between the read and the write pointer.
    function automatic t_ptr fill_count(t_ptr wp, t_ptr rp);
        logic [AW:0] s;
        if (wp >= rp) begin
            s = {1'b0, wp} - {1'b0, rp};
        end else begin
            s = {1'b0, wp} + DEPTH_X - {1'b0, rp};
        end
        return s[AW-1:0];
    endfunction

endpackage

// ----- sv/rbcl_if.sv -----
// Valid/ready channel interfaces for the line reader's input and result words.
`timescale 1ns / 1ps

interface rbcl_in_if ();
    logic       valid;
    logic       ready;
    logic [1:0] operation;
    logic [7:0] data_byte;

    modport source (output valid, output operation, output data_byte, input ready);
    modport sink (input valid, input operation, input data_byte, output ready);
endinterface

interface rbcl_out_if ();
    logic       valid;
    logic       ready;
    logic [7:0] line_byte;
    logic       byte_valid;
    logic [2:0] status;
    logic       last;

    modport source (output valid, output line_byte, output byte_valid, output status,
                    output last, input ready);
    modport sink (input valid, input line_byte, input byte_valid, input status,
                  input last, output ready);
endinterface

// ----- sv/rbcl_front.sv -----
// Front end: accepts input words and turns them into queued commands.
`timescale 1ns / 1ps

module rbcl_front
    import rbcl_pkg::*;
(
    rbcl_in_if.sink i_in,
    input  logic    i_full,
    output logic    o_push,
    output t_cmd    o_cmd
);

    logic accept;

    assign i_in.ready = !i_full;
    assign accept     = i_in.valid && !i_full;

    // The unused operation code is accepted and dropped here.
    always_comb begin
        o_cmd.data = i_in.data_byte;
        o_cmd.kind = CMD_PUSH;
        o_push     = 1'b0;
        case (t_op'(i_in.operation))
            OP_PUSH: begin
                o_cmd.kind = CMD_PUSH;
                o_push     = accept;
            end
            OP_READ: begin
                o_cmd.kind = CMD_READ;
                o_push     = accept;
            end
            OP_CLEAR: begin
                o_cmd.kind = CMD_CLEAR;
                o_push     = accept;
            end
            default: begin
                o_push = 1'b0;
            end
        endcase
    end

endmodule

// ----- sv/rbcl_cmd_queue.sv -----
// Short command queue between the front end and the ring engine.
`timescale 1ns / 1ps

module rbcl_cmd_queue
    import rbcl_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cmd i_cmd,
    output logic o_full,
    output logic o_valid,
    output t_cmd o_cmd,
    input  logic i_pop
);

    t_cmd            r_slot [QUEUE_DEPTH];
    logic [QAW-1:0]  r_wr_ptr;
    logic [QAW-1:0]  r_rd_ptr;
    logic [QCW-1:0]  r_count;
    logic            do_push;
    logic            do_pop;

    assign o_full  = (r_count == QCW'(QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_cmd   = r_slot[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_slot[r_wr_ptr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= r_wr_ptr + QAW'(1);
            end
            if (do_pop) begin
                r_rd_ptr <= r_rd_ptr + QAW'(1);
            end
            case ({do_push, do_pop})
                2'b10:   r_count <= r_count + QCW'(1);
                2'b01:   r_count <= r_count - QCW'(1);
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

// ----- sv/rbcl_back.sv -----
// Ring engine: byte ring memory, line scan, line emission and result register.
`timescale 1ns / 1ps

module rbcl_back
    import rbcl_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_cmd_valid,
    input  t_cmd         i_cmd,
    output logic         o_pop,
    rbcl_out_if.source   o_out
);

    logic [7:0]  mem [DEPTH];
    logic [7:0]  r_rd_data;

    t_back_state r_state, n_state;
    t_ptr        r_wp, n_wp;
    t_ptr        r_rp, n_rp;
    t_ptr        r_cnt, n_cnt;
    t_ptr        r_k, n_k;
    t_ptr        r_len, n_len;
    t_ptr        r_e, n_e;
    logic        r_prev_cr, n_prev_cr;
    t_status     r_fin, n_fin;

    logic        r_out_valid, n_out_valid;
    logic [7:0]  r_out_byte, n_out_byte;
    logic        r_out_bvalid, n_out_bvalid;
    t_status     r_out_status, n_out_status;
    logic        r_out_last, n_out_last;

    logic        out_free;
    logic        mem_we;
    t_ptr        mem_wa;
    logic [7:0]  mem_wd;
    logic        rd_en;
    t_ptr        rd_addr;
    t_ptr        wp_next;
    t_ptr        cnt_now;
    logic        found;

    assign out_free         = !r_out_valid || o_out.ready;
    assign o_out.valid      = r_out_valid;
    assign o_out.line_byte  = r_out_byte;
    assign o_out.byte_valid = r_out_bvalid;
    assign o_out.status     = r_out_status;
    assign o_out.last       = r_out_last;

    assign wp_next = wrap_add(r_wp, t_ptr'(1));
    assign cnt_now = fill_count(r_wp, r_rp);
    // A CRLF ending at the current byte counts only when the line before it is not empty.
    assign found   = (r_k >= t_ptr'(2)) && r_prev_cr && (r_rd_data == CH_LF);

    // Slots outside the stored span are never read, so the ring needs no clearing.
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_wa] <= mem_wd;
        end
        if (rd_en) begin
            r_rd_data <= mem[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= BK_IDLE;
            r_wp        <= '0;
            r_rp        <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_wp        <= n_wp;
            r_rp        <= n_rp;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cnt        <= n_cnt;
        r_k          <= n_k;
        r_len        <= n_len;
        r_e          <= n_e;
        r_prev_cr    <= n_prev_cr;
        r_fin        <= n_fin;
        r_out_byte   <= n_out_byte;
        r_out_bvalid <= n_out_bvalid;
        r_out_status <= n_out_status;
        r_out_last   <= n_out_last;
    end

    always_comb begin
        n_state      = r_state;
        n_wp         = r_wp;
        n_rp         = r_rp;
        n_cnt        = r_cnt;
        n_k          = r_k;
        n_len        = r_len;
        n_e          = r_e;
        n_prev_cr    = r_prev_cr;
        n_fin        = r_fin;
        n_out_valid  = r_out_valid && !o_out.ready;
        n_out_byte   = r_out_byte;
        n_out_bvalid = r_out_bvalid;
        n_out_status = r_out_status;
        n_out_last   = r_out_last;
        o_pop        = 1'b0;
        mem_we       = 1'b0;
        mem_wa       = r_wp;
        mem_wd       = i_cmd.data;
        rd_en        = 1'b0;
        rd_addr      = r_rp;

        case (r_state)
            BK_IDLE: begin
                if (i_cmd_valid) begin
                    o_pop   = 1'b1;
                    n_state = BK_FIN;
                    case (i_cmd.kind)
                        CMD_PUSH: begin
                            if (wp_next == r_rp) begin
                                n_fin = ST_DROPPED;
                            end else begin
                                mem_we = 1'b1;
                                n_wp   = wp_next;
                                n_fin  = ST_STORED;
                            end
                        end
                        CMD_READ: begin
                            if (cnt_now < t_ptr'(2)) begin
                                n_fin = ST_EMPTY;
                            end else begin
                                n_cnt     = cnt_now;
                                rd_en     = 1'b1;
                                rd_addr   = r_rp;
                                n_k       = '0;
                                n_prev_cr = 1'b0;
                                n_state   = BK_SCAN;
                            end
                        end
                        CMD_CLEAR: begin
                            n_wp  = '0;
                            n_rp  = '0;
                            n_fin = ST_CLEARED;
                        end
                        default: begin
                            n_state = BK_IDLE;
                        end
                    endcase
                end
            end
            BK_SCAN: begin
                // r_rd_data holds the stored byte at offset r_k from the read pointer.
                if (found) begin
                    n_len   = r_k - t_ptr'(1);
                    n_e     = '0;
                    rd_en   = 1'b1;
                    rd_addr = r_rp;
                    n_state = BK_EMIT;
                end else if (32'(r_k) == MAX_LINE) begin
                    n_wp    = '0;
                    n_rp    = '0;
                    n_fin   = ST_TOO_LONG;
                    n_state = BK_FIN;
                end else if (r_k == r_cnt - t_ptr'(1)) begin
                    n_fin   = ST_NO_LINE;
                    n_state = BK_FIN;
                end else begin
                    rd_en     = 1'b1;
                    rd_addr   = wrap_add(r_rp, r_k + t_ptr'(1));
                    n_k       = r_k + t_ptr'(1);
                    n_prev_cr = (r_rd_data == CH_CR);
                end
            end
            BK_EMIT: begin
                if (out_free) begin
                    n_out_valid  = 1'b1;
                    n_out_byte   = r_rd_data;
                    n_out_bvalid = 1'b1;
                    n_out_status = ST_LINE_OK;
                    n_out_last   = 1'b0;
                    if (r_e == r_len - t_ptr'(1)) begin
                        n_fin   = ST_LINE_OK;
                        n_state = BK_FIN;
                    end else begin
                        rd_en   = 1'b1;
                        rd_addr = wrap_add(r_rp, r_e + t_ptr'(1));
                        n_e     = r_e + t_ptr'(1);
                    end
                end
            end
            BK_FIN: begin
                if (out_free) begin
                    n_out_valid  = 1'b1;
                    n_out_byte   = 8'h00;
                    n_out_bvalid = 1'b0;
                    n_out_status = r_fin;
                    n_out_last   = 1'b1;
                    if (r_fin == ST_LINE_OK) begin
                        // Consume the line together with its CR and LF.
                        n_rp = wrap_add(r_rp, r_len + t_ptr'(2));
                    end
                    n_state = BK_IDLE;
                end
            end
            default: begin
                n_state = BK_IDLE;
            end
        endcase
    end

endmodule

// ----- sv/ring_buffer_crlf_line_reader.sv -----
// Top level of the receive ring with CRLF line extraction.
//
//   Port    Dir  Word carried
//   i_in    in   operation, data_byte
//   o_out   out  line_byte, byte_valid, status, last
//
// Push, clear and short reads each put one status word on o_out, sent from the BK_FIN state.
// A line read walks the ring one byte per cycle through the single memory read port,
// up to offset MAX_LINE, then sends the L line bytes, if a line was found, and a status word.
// Reset clears pointers, state and output valid; slots outside the span are never read.
// A two-word command queue keeps the input open while the engine waits on o_out.ready.
`timescale 1ns / 1ps
`include "ring_buffer_crlf_line_reader_assert.svh"

module ring_buffer_crlf_line_reader
    import rbcl_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    rbcl_in_if.sink    i_in,
    rbcl_out_if.source o_out
);

    logic q_push;
    t_cmd q_in_cmd;
    logic q_full;
    logic q_valid;
    t_cmd q_out_cmd;
    logic q_pop;

    rbcl_front u_front (
        .i_in   (i_in),
        .i_full (q_full),
        .o_push (q_push),
        .o_cmd  (q_in_cmd)
    );

    rbcl_cmd_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_cmd   (q_in_cmd),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_cmd   (q_out_cmd),
        .i_pop   (q_pop)
    );

    rbcl_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (q_valid),
        .i_cmd       (q_out_cmd),
        .o_pop       (q_pop),
        .o_out       (o_out)
    );

    `RBCL_ASSERT(a_line_byte_word, o_out.valid && o_out.byte_valid, (o_out.status == ST_LINE_OK) && !o_out.last, "line byte word with wrong status or last")
    `RBCL_ASSERT(a_status_word, o_out.valid && !o_out.byte_valid, o_out.last && (o_out.line_byte == 8'h00), "status word not final or carries a byte")
    `RBCL_ASSERT(a_unused_op_dropped, i_in.valid && i_in.ready && (i_in.operation == OP_NONE), !q_push, "unused operation reached the queue")
    `RBCL_ASSERT_NEXT(a_push_lands, q_push && !q_full, q_valid, "queued command missing")

endmodule

// ----- test/tb_ring_buffer_crlf_line_reader.sv -----
// Testbench for the CRLF line reader: directed, full-ring and random traffic against a predictor.
`timescale 1ns / 1ps

module tb_ring_buffer_crlf_line_reader;
    import rbcl_pkg::*;

    typedef struct packed {
        logic [7:0] line_byte;
        logic       byte_valid;
        t_status    status;
        logic       last;
    } t_result_word;

    localparam int DRAIN_CYCLES = 2 * MAX_LINE + 8;

    logic i_clk;
    logic i_rst_n;

    rbcl_in_if  in_ch ();
    rbcl_out_if out_ch ();

    ring_buffer_crlf_line_reader uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    // Predictor state: a copy of the byte ring and its two pointers.
    logic [7:0]   ring_copy [DEPTH];
    int           ring_wr;
    int           ring_rd;
    t_result_word pending_words [$];

    int error_count    = 0;
    int words_sent     = 0;
    int hold_request   = 0;
    bit gaps_enabled   = 1'b1;
    bit stalls_enabled = 1'b1;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #10_000_000;
        $display("tb_ring_buffer_crlf_line_reader failed");
        $finish;
    end

    function automatic void clear_ring_copy();
        for (int i = 0; i < DEPTH; i++) begin
            ring_copy[i] = 8'h00;
        end
        ring_wr = 0;
        ring_rd = 0;
    endfunction

    function automatic void queue_status_word(t_status st);
        t_result_word w;
        w.line_byte  = 8'h00;
        w.byte_valid = 1'b0;
        w.status     = st;
        w.last       = 1'b1;
        pending_words.push_back(w);
    endfunction

    function automatic void predict_line_read();
        int           count;
        int           at;
        bit           found;
        t_result_word w;
        count = (ring_wr + DEPTH - ring_rd) % DEPTH;
        if (count < 2) begin
            queue_status_word(ST_EMPTY);
            return;
        end
        for (int j = 0; j < count; j++) begin
            found = (j + 1 < count)
                && ring_copy[(ring_rd + j) % DEPTH] == CH_CR
                && ring_copy[(ring_rd + j + 1) % DEPTH] == CH_LF;
            if (j >= MAX_LINE) begin
                clear_ring_copy();
                queue_status_word(ST_TOO_LONG);
                return;
            end
            // A CRLF right at the read pointer does not end a line.
            if (j != 0 && found) begin
                for (int k = 0; k < j; k++) begin
                    at = (ring_rd + k) % DEPTH;
                    w.line_byte  = ring_copy[at];
                    w.byte_valid = 1'b1;
                    w.status     = ST_LINE_OK;
                    w.last       = 1'b0;
                    pending_words.push_back(w);
                    ring_copy[at] = 8'h00;
                end
                ring_copy[(ring_rd + j) % DEPTH]     = 8'h00;
                ring_copy[(ring_rd + j + 1) % DEPTH] = 8'h00;
                ring_rd = (ring_rd + j + 2) % DEPTH;
                queue_status_word(ST_LINE_OK);
                return;
            end
        end
        queue_status_word(ST_NO_LINE);
    endfunction

    function automatic void predict_ring_op(t_op op, logic [7:0] b);
        case (op)
            OP_PUSH: begin
                if ((ring_wr + 1) % DEPTH == ring_rd) begin
                    queue_status_word(ST_DROPPED);
                end else begin
                    ring_copy[ring_wr] = b;
                    ring_wr = (ring_wr + 1) % DEPTH;
                    queue_status_word(ST_STORED);
                end
            end
            OP_READ:  predict_line_read();
            OP_CLEAR: begin
                clear_ring_copy();
                queue_status_word(ST_CLEARED);
            end
            default: ;
        endcase
    endfunction

    // Offers one word, waits for it to be taken and records what it should cause.
    task automatic send_word(t_op op, logic [7:0] b);
        if (gaps_enabled && $urandom_range(0, 4) == 0) begin
            in_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
        in_ch.valid     <= 1'b1;
        in_ch.operation <= op;
        in_ch.data_byte <= b;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        predict_ring_op(op, b);
        if (op != OP_NONE) begin
            words_sent++;
        end
    endtask

    task automatic release_input();
        in_ch.valid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic wait_results_drained(int limit);
        int waited;
        waited = 0;
        release_input();
        while (pending_words.size() > 0 && waited < limit) begin
            @(posedge i_clk);
            waited++;
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    function automatic logic [7:0] random_non_cr();
        logic [7:0] b;
        do begin
            b = 8'($urandom_range(0, 255));
        end while (b == CH_CR);
        return b;
    endfunction

    task automatic push_line(int len, bit allow_ctl);
        for (int k = 0; k < len; k++) begin
            send_word(OP_PUSH, allow_ctl ? 8'($urandom_range(0, 255)) : random_non_cr());
        end
        send_word(OP_PUSH, CH_CR);
        send_word(OP_PUSH, CH_LF);
    endtask

    task automatic test_directed_cases();
        send_word(OP_CLEAR, 8'hFF);
        send_word(OP_READ, 8'h00);
        send_word(OP_PUSH, 8'h00);
        send_word(OP_READ, 8'hFF);
        send_word(OP_PUSH, 8'hFF);
        // A trailing CR with no LF stored yet is not a line end.
        send_word(OP_PUSH, CH_CR);
        send_word(OP_READ, 8'h00);
        send_word(OP_PUSH, CH_LF);
        send_word(OP_READ, 8'h00);
        // The leading CRLF is kept and becomes part of the line.
        send_word(OP_PUSH, CH_CR);
        send_word(OP_PUSH, CH_LF);
        send_word(OP_PUSH, 8'h41);
        send_word(OP_PUSH, CH_CR);
        send_word(OP_PUSH, CH_LF);
        send_word(OP_READ, 8'h55);
        send_word(OP_NONE, 8'hA5);
        send_word(OP_READ, 8'hAA);
        send_word(OP_PUSH, 8'h42);
        send_word(OP_PUSH, CH_LF);
        send_word(OP_READ, 8'h00);
        send_word(OP_CLEAR, 8'h00);
        send_word(OP_READ, 8'h00);
        wait_results_drained(10000);
    endtask

    // Holds off the result side while the ring is pushed past full.
    task automatic test_full_ring_stall();
        send_word(OP_CLEAR, 8'h00);
        send_word(OP_PUSH, 8'h41);
        send_word(OP_PUSH, CH_CR);
        send_word(OP_PUSH, CH_LF);
        hold_request = 300;
        for (int i = 0; i < DEPTH - 1; i++) begin
            send_word(OP_PUSH, random_non_cr());
        end
        send_word(OP_READ, 8'h00);
        send_word(OP_PUSH, random_non_cr());
        send_word(OP_READ, 8'h00);
        send_word(OP_READ, 8'h00);
    endtask

    // Runs random traffic until the count of sent words other than OP_NONE reaches item_goal.
    task automatic test_random_traffic(int item_goal);
        int pick;
        int len;
        int pause_at;
        bit paused;
        paused   = 1'b0;
        pause_at = words_sent + (item_goal - words_sent) / 2;
        while (words_sent < item_goal) begin
            if (!paused && words_sent >= pause_at) begin
                wait_results_drained(100000);
                paused = 1'b1;
            end
            if (words_sent >= item_goal - 25) begin
                gaps_enabled   = 1'b0;
                stalls_enabled = 1'b0;
            end
            pick = $urandom_range(0, 99);
            if (pick < 65) begin
                len = ($urandom_range(0, 4) == 0) ? $urandom_range(28, 34)
                                                  : $urandom_range(0, 12);
                push_line(len, $urandom_range(0, 7) == 0);
                if ($urandom_range(0, 4) != 0) begin
                    send_word(OP_READ, 8'($urandom_range(0, 255)));
                end
            end else if (pick < 77) begin
                send_word(OP_READ, 8'($urandom_range(0, 255)));
            end else if (pick < 87) begin
                repeat ($urandom_range(1, 3)) begin
                    case ($urandom_range(0, 2))
                        0:       send_word(OP_PUSH, CH_CR);
                        1:       send_word(OP_PUSH, CH_LF);
                        default: send_word(OP_PUSH, 8'($urandom_range(0, 255)));
                    endcase
                end
            end else if (pick < 93) begin
                // CR followed by something other than LF.
                send_word(OP_PUSH, CH_CR);
                send_word(OP_PUSH, ($urandom_range(0, 1) == 0) ? CH_CR : 8'h20);
                send_word(OP_READ, 8'($urandom_range(0, 255)));
            end else if (pick < 97) begin
                send_word(OP_CLEAR, 8'($urandom_range(0, 255)));
            end else begin
                send_word(OP_NONE, 8'($urandom_range(0, 255)));
            end
        end
    endtask

    initial begin : drive_result_ready
        int stall_left;
        stall_left = 0;
        out_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_request > 0) begin
                stall_left   = hold_request;
                hold_request = 0;
            end
            if (stall_left > 0) begin
                out_ch.ready <= 1'b0;
                stall_left--;
            end else if (stalls_enabled && $urandom_range(0, 5) == 0) begin
                out_ch.ready <= 1'b0;
                stall_left = $urandom_range(0, 3);
            end else begin
                out_ch.ready <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin : check_result_words
        t_result_word exp_w;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            if (pending_words.size() == 0) begin
                $error("unexpected result word: line_byte %h status %0d",
                       out_ch.line_byte, out_ch.status);
                error_count++;
            end else begin
                exp_w = pending_words.pop_front();
                if (out_ch.line_byte !== exp_w.line_byte) begin
                    $error("line_byte: expected %h, actual %h", exp_w.line_byte,
                           out_ch.line_byte);
                    error_count++;
                end
                if (out_ch.byte_valid !== exp_w.byte_valid) begin
                    $error("byte_valid: expected %b, actual %b", exp_w.byte_valid,
                           out_ch.byte_valid);
                    error_count++;
                end
                if (out_ch.status !== exp_w.status) begin
                    $error("status: expected %0d, actual %0d", exp_w.status, out_ch.status);
                    error_count++;
                end
                if (out_ch.last !== exp_w.last) begin
                    $error("last: expected %b, actual %b", exp_w.last, out_ch.last);
                    error_count++;
                end
            end
        end
    end

    initial begin
        clear_ring_copy();
        i_rst_n         <= 1'b0;
        in_ch.valid     <= 1'b0;
        in_ch.operation <= OP_PUSH;
        in_ch.data_byte <= 8'h00;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed_cases();
        test_full_ring_stall();
        test_random_traffic(350);

        wait_results_drained(200000);
        if (pending_words.size() != 0) begin
            $error("%0d expected result words never arrived", pending_words.size());
            error_count++;
        end
        if (error_count == 0) begin
            $display("tb_ring_buffer_crlf_line_reader passed");
        end else begin
            $display("tb_ring_buffer_crlf_line_reader failed");
        end
        $finish;
    end

endmodule

// ----- files.f -----
+incdir+sv
sv/rbcl_pkg.sv
sv/rbcl_if.sv
sv/rbcl_front.sv
sv/rbcl_cmd_queue.sv
sv/rbcl_back.sv
sv/ring_buffer_crlf_line_reader.sv
test/tb_ring_buffer_crlf_line_reader.sv
